// File: sv/caws_pkg.sv
// Shared types and constants for the cumulative-ACK window sender.
package caws_pkg;

  localparam int unsigned MAX_WINDOW_DEF   = 8;
  localparam int unsigned SEQ_BITS_DEF     = 16;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  localparam int unsigned WSIZE_BITS  = 4;
  localparam int unsigned DUP_BITS    = 3;
  localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 4'd4;
  localparam logic [DUP_BITS-1:0]   DUP_TRIGGER = 3'd3;
  localparam logic [DUP_BITS-1:0]   DUP_MAX     = 3'd7;

  typedef enum logic [1:0] {
    REQ_SEND    = 2'd0,
    REQ_ACK     = 2'd1,
    REQ_TIMEOUT = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } timer_cmd_e;

  typedef enum logic [1:0] {
    PAY_ZERO  = 2'd0,
    PAY_INPUT = 2'd1,
    PAY_STORE = 2'd2
  } pay_src_e;

endpackage

// File: sv/cumulative_ack_window_sender_top.sv
// Cumulative-ACK sliding-window sender: window state, packet store and result register.
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle; in_ready_o drops only while a result waits unread.
// A retransmitted payload is read from the store at accept and lands in the result register.
// Reset: asynchronous, active low; window state returns to its initial values,
// the packet store is not cleared.
module cumulative_ack_window_sender_top
  import caws_pkg::*;
#(
  parameter int unsigned MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int unsigned SEQ_BITS     = SEQ_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [WSIZE_BITS-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              req_type_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  input  logic [SEQ_BITS-1:0]     ack_num_i,
  input  logic                    ack_ok_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    accepted_o,
  output logic                    tx_valid_o,
  output logic [SEQ_BITS-1:0]     tx_seq_o,
  output logic [PAYLOAD_BITS-1:0] tx_payload_o,
  output logic [1:0]              timer_cmd_o,
  output logic [SEQ_BITS-1:0]     timer_seq_o,
  output logic                    window_full_o
);

  localparam int unsigned SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [SLOT_W:0] SLOT_DEPTH = (SLOT_W + 1)'(MAX_WINDOW);

  logic [WSIZE_BITS-1:0] wsize_q;
  logic [SEQ_BITS-1:0]   base_q, base_d;
  logic [SEQ_BITS-1:0]   next_q, next_d;
  logic [SEQ_BITS-1:0]   last_ack_q, last_ack_d;
  logic [DUP_BITS-1:0]   dup_q, dup_d;
  logic                  wait_q, wait_d;
  logic [SLOT_W-1:0]     bslot_q, bslot_d;

  logic [PAYLOAD_BITS-1:0] store_q [MAX_WINDOW];
  logic [PAYLOAD_BITS-1:0] rd_q;

  logic                    ovalid_q;
  logic                    acc_q, acc_d;
  logic                    txv_q, txv_d;
  logic [SEQ_BITS-1:0]     txs_q, txs_d;
  logic [PAYLOAD_BITS-1:0] pay_q;
  pay_src_e                src_q, src_d;
  timer_cmd_e              tcmd_q, tcmd_d;
  logic [SEQ_BITS-1:0]     tseq_q, tseq_d;

  logic                  take;
  logic                  st_we;
  logic [SLOT_W-1:0]     wslot;
  logic [SEQ_BITS-1:0]   eff_win;
  logic [SEQ_BITS-1:0]   outs;
  logic [SEQ_BITS-1:0]   ack_off;
  logic [SEQ_BITS-1:0]   next_inc;
  logic [SEQ_BITS-1:0]   ack_inc;
  logic [SLOT_W:0]       wsum;
  logic [SLOT_W:0]       asum;
  logic [DUP_BITS-1:0]   dup_inc;

  assign in_ready_o = !ovalid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    if (wsize_q == '0) begin
      eff_win = SEQ_BITS'(1);
    end else if (int'(wsize_q) > int'(MAX_WINDOW)) begin
      eff_win = SEQ_BITS'(MAX_WINDOW);
    end else begin
      eff_win = SEQ_BITS'(wsize_q);
    end
  end

  assign outs     = next_q - base_q;
  assign ack_off  = ack_num_i - base_q;
  assign next_inc = next_q + SEQ_BITS'(1);
  assign ack_inc  = ack_num_i + SEQ_BITS'(1);
  assign dup_inc  = (dup_q < DUP_MAX) ? dup_q + DUP_BITS'(1) : dup_q;

  // outs < MAX_WINDOW on an accepted send; ack offset + 1 <= MAX_WINDOW on a new ACK
  assign wsum  = {1'b0, bslot_q} + (SLOT_W + 1)'(outs);
  assign asum  = {1'b0, bslot_q} + (SLOT_W + 1)'(ack_off) + (SLOT_W + 1)'(1);
  assign wslot = (wsum >= SLOT_DEPTH) ? SLOT_W'(wsum - SLOT_DEPTH) : SLOT_W'(wsum);

  always_comb begin
    base_d     = base_q;
    next_d     = next_q;
    last_ack_d = last_ack_q;
    dup_d      = dup_q;
    wait_d     = wait_q;
    bslot_d    = bslot_q;
    st_we      = 1'b0;
    acc_d      = 1'b0;
    txv_d      = 1'b0;
    txs_d      = '0;
    src_d      = PAY_ZERO;
    tcmd_d     = TMR_NONE;
    tseq_d     = '0;
    unique case (req_type_i)
      REQ_SEND: begin
        if (outs >= eff_win) begin
          wait_d = 1'b1;
        end else begin
          st_we  = 1'b1;
          acc_d  = 1'b1;
          txv_d  = 1'b1;
          txs_d  = next_q;
          src_d  = PAY_INPUT;
          if (outs == '0) begin
            tcmd_d = TMR_START;
            tseq_d = base_q;
          end
          next_d = next_inc;
          wait_d = ((next_inc - base_q) >= eff_win);
        end
      end
      REQ_ACK: begin
        if (ack_ok_i) begin
          if (ack_off < outs) begin
            bslot_d    = (asum >= SLOT_DEPTH) ? SLOT_W'(asum - SLOT_DEPTH) : SLOT_W'(asum);
            base_d     = ack_inc;
            dup_d      = '0;
            last_ack_d = ack_num_i;
            if (next_q != ack_inc) begin
              tcmd_d = TMR_RESTART;
              tseq_d = ack_inc;
            end else begin
              tcmd_d = TMR_STOP;
              tseq_d = base_q;
            end
            wait_d = ((next_q - ack_inc) >= eff_win);
          end else if (ack_num_i == last_ack_q) begin
            dup_d = dup_inc;
            if (dup_inc == DUP_TRIGGER && outs != '0) begin
              txv_d  = 1'b1;
              txs_d  = base_q;
              src_d  = PAY_STORE;
              tcmd_d = TMR_RESTART;
              tseq_d = base_q;
              dup_d  = '0;
            end
          end
        end
      end
      REQ_TIMEOUT: begin
        if (outs != '0) begin
          txv_d  = 1'b1;
          txs_d  = base_q;
          src_d  = PAY_STORE;
          tcmd_d = TMR_RESTART;
          tseq_d = base_q;
          dup_d  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= WSIZE_RESET;
    end else if (cfg_we_i) begin
      wsize_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= SEQ_BITS'(1);
      next_q     <= SEQ_BITS'(1);
      last_ack_q <= '0;
      dup_q      <= '0;
      wait_q     <= 1'b0;
      bslot_q    <= '0;
      ovalid_q   <= 1'b0;
      src_q      <= PAY_ZERO;
    end else begin
      if (take) begin
        base_q     <= base_d;
        next_q     <= next_d;
        last_ack_q <= last_ack_d;
        dup_q      <= dup_d;
        wait_q     <= wait_d;
        bslot_q    <= bslot_d;
        src_q      <= src_d;
        ovalid_q   <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q   <= 1'b0;
      end
    end
  end

  // a send writes its slot; the base slot is read on every item for a retransmit
  always_ff @(posedge clk_i) begin
    if (take && st_we) begin
      store_q[wslot] <= payload_i;
    end
    if (take) begin
      rd_q <= store_q[bslot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q  <= acc_d;
      txv_q  <= txv_d;
      txs_q  <= txs_d;
      pay_q  <= payload_i;
      tcmd_q <= tcmd_d;
      tseq_q <= tseq_d;
    end
  end

  always_comb begin
    unique case (src_q)
      PAY_INPUT: tx_payload_o = pay_q;
      PAY_STORE: tx_payload_o = rd_q;
      default:   tx_payload_o = '0;
    endcase
  end

  assign out_valid_o   = ovalid_q;
  assign accepted_o    = acc_q;
  assign tx_valid_o    = txv_q;
  assign tx_seq_o      = txs_q;
  assign timer_cmd_o   = tcmd_q;
  assign timer_seq_o   = tseq_q;
  assign window_full_o = wait_q;

endmodule

// File: sv/caws_checker.sv
// Port-level assertions for the window sender, bound to the top level.
module caws_checker
  import caws_pkg::*;
#(
  parameter int unsigned SEQ_BITS     = SEQ_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic                    accepted_o,
  input logic                    tx_valid_o,
  input logic [SEQ_BITS-1:0]     tx_seq_o,
  input logic [PAYLOAD_BITS-1:0] tx_payload_o,
  input logic [1:0]              timer_cmd_o,
  input logic [SEQ_BITS-1:0]     timer_seq_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_seq_o)
      && $stable(tx_payload_o) && $stable(timer_seq_o))
    else $error("result changed while stalled");

  a_idle_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> tx_seq_o == '0 && tx_payload_o == '0)
    else $error("packet fields set without emission");

  a_acc_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> tx_valid_o
      && (timer_cmd_o == TMR_NONE || timer_cmd_o == TMR_START))
    else $error("accepted send without emission");

  a_tmr_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && timer_cmd_o == TMR_NONE |-> timer_seq_o == '0)
    else $error("timer sequence without command");

endmodule

bind cumulative_ack_window_sender_top caws_checker #(
  .SEQ_BITS     (SEQ_BITS),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_caws_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .accepted_o   (accepted_o),
  .tx_valid_o   (tx_valid_o),
  .tx_seq_o     (tx_seq_o),
  .tx_payload_o (tx_payload_o),
  .timer_cmd_o  (timer_cmd_o),
  .timer_seq_o  (timer_seq_o)
);

// File: tb/cumulative_ack_window_sender_top_tb.sv
// Testbench for the cumulative-ACK window sender: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module cumulative_ack_window_sender_top_tb;
  import caws_pkg::*;

  localparam int unsigned SEQ_W       = SEQ_BITS_DEF;
  localparam int unsigned PAY_W       = PAYLOAD_BITS_DEF;
  localparam int unsigned WIN_MAX     = MAX_WINDOW_DEF;
  localparam int unsigned SLOT_W      = $clog2(WIN_MAX);
  localparam int unsigned GAP_MAX     = 14;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam logic [1:0]  REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic             accepted;
    logic             tx_valid;
    logic [SEQ_W-1:0] tx_seq;
    logic [PAY_W-1:0] tx_payload;
    timer_cmd_e       timer_cmd;
    logic [SEQ_W-1:0] timer_seq;
    logic             window_full;
  } sender_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [WSIZE_BITS-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            req_type_i;
  logic [PAY_W-1:0]      payload_i;
  logic [SEQ_W-1:0]      ack_num_i;
  logic                  ack_ok_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  accepted_o;
  logic                  tx_valid_o;
  logic [SEQ_W-1:0]      tx_seq_o;
  logic [PAY_W-1:0]      tx_payload_o;
  logic [1:0]            timer_cmd_o;
  logic [SEQ_W-1:0]      timer_seq_o;
  logic                  window_full_o;

  // predictor state
  logic [WSIZE_BITS-1:0] win_size  = WSIZE_RESET;
  logic [SEQ_W-1:0]      base_seq  = SEQ_W'(1);
  logic [SEQ_W-1:0]      next_seq  = SEQ_W'(1);
  logic [SEQ_W-1:0]      last_acked = '0;
  logic [DUP_BITS-1:0]   dup_cnt   = '0;
  logic                  full_flag = 1'b0;
  logic [PAY_W-1:0]      pkt_store [WIN_MAX];
  int unsigned           head_slot = 0;

  sender_result_t pending_results[$];
  int unsigned    mismatch_count = 0;
  int unsigned    tx_gap_max     = GAP_MAX;
  int unsigned    rx_stall_max   = GAP_MAX;
  int unsigned    rx_hold        = 0;

  cumulative_ack_window_sender_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .payload_i     (payload_i),
    .ack_num_i     (ack_num_i),
    .ack_ok_i      (ack_ok_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .accepted_o    (accepted_o),
    .tx_valid_o    (tx_valid_o),
    .tx_seq_o      (tx_seq_o),
    .tx_payload_o  (tx_payload_o),
    .timer_cmd_o   (timer_cmd_o),
    .timer_seq_o   (timer_seq_o),
    .window_full_o (window_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [SEQ_W-1:0] in_flight();
    return next_seq - base_seq;
  endfunction

  function automatic sender_result_t predict_sender_result(input logic [1:0] req,
      input logic [PAY_W-1:0] pay, input logic [SEQ_W-1:0] ack, input logic ok);
    sender_result_t   r;
    logic [SEQ_W-1:0] inflight;
    logic [SEQ_W-1:0] offset;
    logic [SEQ_W-1:0] old_base;
    int unsigned      limit;
    logic             resend;
    r        = '0;
    resend   = 1'b0;
    limit    = (win_size == 0) ? 1 : ((win_size > WIN_MAX) ? WIN_MAX : win_size);
    inflight = in_flight();
    if (req == REQ_SEND) begin
      if (inflight >= limit) begin
        full_flag = 1'b1;
      end else begin
        pkt_store[SLOT_W'((head_slot + inflight) % WIN_MAX)] = pay;
        r.accepted   = 1'b1;
        r.tx_valid   = 1'b1;
        r.tx_seq     = next_seq;
        r.tx_payload = pay;
        if (inflight == 0) begin
          r.timer_cmd = TMR_START;
          r.timer_seq = base_seq;
        end
        next_seq  = next_seq + 1'b1;
        full_flag = (in_flight() >= limit);
      end
    end else if (req == REQ_ACK && ok) begin
      offset = ack - base_seq;
      if (offset < inflight) begin
        old_base   = base_seq;
        head_slot  = (head_slot + offset + 1) % WIN_MAX;
        base_seq   = ack + 1'b1;
        dup_cnt    = '0;
        last_acked = ack;
        if (in_flight() != 0) begin
          r.timer_cmd = TMR_RESTART;
          r.timer_seq = base_seq;
        end else begin
          r.timer_cmd = TMR_STOP;
          r.timer_seq = old_base;
        end
        full_flag = (in_flight() >= limit);
      end else if (ack == last_acked) begin
        if (dup_cnt < DUP_MAX) dup_cnt = dup_cnt + 1'b1;
        resend = (dup_cnt == DUP_TRIGGER) && (inflight != 0);
      end
    end else if (req == REQ_TIMEOUT) begin
      resend = (inflight != 0);
    end
    if (resend) begin
      r.tx_valid   = 1'b1;
      r.tx_seq     = base_seq;
      r.tx_payload = pkt_store[SLOT_W'(head_slot)];
      r.timer_cmd  = TMR_RESTART;
      r.timer_seq  = base_seq;
      dup_cnt      = '0;
    end
    r.window_full = full_flag;
    return r;
  endfunction

  task automatic send_request(input logic [1:0] req, input logic [PAY_W-1:0] pay,
                              input logic [SEQ_W-1:0] ack, input logic ok);
    int unsigned gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    payload_i  <= pay;
    ack_num_i  <= ack;
    ack_ok_i   <= ok;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_sender_result(req, pay, ack, ok));
  endtask

  // random sends, timeouts and acks, the acks mostly well-formed and near the window, plus noise
  task automatic send_random();
    int unsigned      pick;
    logic [1:0]       req;
    logic [PAY_W-1:0] pay;
    logic [SEQ_W-1:0] ack;
    logic [SEQ_W-1:0] span;
    logic             ok;
    pick = $urandom_range(99, 0);
    pay  = $urandom;
    ack  = SEQ_W'($urandom);
    ok   = 1'($urandom);
    if (pick < 45) begin
      req = REQ_SEND;
    end else if (pick < 80) begin
      req = REQ_ACK;
      ok  = 1'b1;
      if (pick < 58) begin
        ack = last_acked;
      end else begin
        span = SEQ_W'($urandom_range(in_flight(), 0));
        ack  = base_seq - 1'b1 + span;
      end
    end else if (pick < 90) begin
      req = REQ_ACK;
    end else if (pick < 97) begin
      req = REQ_TIMEOUT;
    end else begin
      req = REQ_UNKNOWN;
    end
    send_request(req, pay, ack, ok);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WSIZE_BITS-1:0] w);
    wait_results_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    win_size = w;
    cfg_we_i <= 1'b0;
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // results checked in order
  initial begin : result_check
    sender_result_t want;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual seq %0h", $time, tx_seq_o);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          report_field("accepted", 64'(want.accepted), 64'(accepted_o));
          report_field("tx_valid", 64'(want.tx_valid), 64'(tx_valid_o));
          report_field("tx_seq", 64'(want.tx_seq), 64'(tx_seq_o));
          report_field("tx_payload", 64'(want.tx_payload), 64'(tx_payload_o));
          report_field("timer_cmd", 64'(want.timer_cmd), 64'(timer_cmd_o));
          report_field("timer_seq", 64'(want.timer_seq), 64'(timer_seq_o));
          report_field("window_full", 64'(want.window_full), 64'(window_full_o));
        end
      end
    end
  end

  // receiver: per-result stall, plus long hold-offs on request
  initial begin : result_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) stall = $urandom_range(rx_stall_max, 0);
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no item moved for %0d cycles", $time, quiet);
    $display("*** FAILED ***");
    $finish;
  end

  // nothing outstanding: timeout, duplicate ack saturation, corrupt ack, unknown request
  task automatic test_idle_requests();
    send_request(REQ_TIMEOUT, '0, '0, 1'b1);
    repeat (8) send_request(REQ_ACK, '0, '0, 1'b1);
    send_request(REQ_ACK, '1, 16'd1, 1'b0);
    send_request(REQ_UNKNOWN, '1, '1, 1'b1);
  endtask

  // window of 4: fill, then one refused send
  task automatic test_window_fill();
    send_request(REQ_SEND, 32'h0000_0000, '1, 1'b0);
    send_request(REQ_SEND, 32'hFFFF_FFFF, '0, 1'b1);
    send_request(REQ_SEND, 32'hA5A5_A5A5, 16'h5A5A, 1'b0);
    send_request(REQ_SEND, 32'h5A5A_5A5A, 16'hA5A5, 1'b1);
    send_request(REQ_SEND, 32'h1234_5678, '0, 1'b0);
  endtask

  // new ack, fast retransmit, timeout, stale and future acks, corrupt ack, full ack
  task automatic test_ack_handling();
    send_request(REQ_ACK, '0, 16'd1, 1'b1);
    repeat (3) send_request(REQ_ACK, '0, 16'd1, 1'b1);
    send_request(REQ_TIMEOUT, '0, '0, 1'b0);
    send_request(REQ_ACK, '0, 16'hFFFF, 1'b1);
    send_request(REQ_ACK, '0, 16'd9, 1'b1);
    send_request(REQ_ACK, '0, 16'd3, 1'b0);
    send_request(REQ_ACK, '0, 16'd4, 1'b1);
  endtask

  task automatic test_window_extremes();
    logic [WSIZE_BITS-1:0] sizes [4];
    sizes = '{4'd1, 4'd8, 4'd0, 4'd15};
    foreach (sizes[i]) begin
      write_window(sizes[i]);
      repeat (50) send_random();
    end
  endtask

  task automatic test_backpressure();
    write_window(WSIZE_BITS'($urandom_range(7, 2)));
    tx_gap_max = 0;
    rx_hold    = 80;
    repeat (40) send_random();
    tx_gap_max = GAP_MAX;
  endtask

  // full windows back to back, each cleared by one cumulative ack
  task automatic test_full_windows();
    write_window(4'd15);
    tx_gap_max   = 0;
    rx_stall_max = 0;
    repeat (6) begin
      send_request(REQ_ACK, $urandom, next_seq - 1'b1, 1'b1);
      while (in_flight() < WIN_MAX) begin
        send_request(REQ_SEND, $urandom, SEQ_W'($urandom), 1'($urandom));
      end
    end
    tx_gap_max   = GAP_MAX;
    rx_stall_max = GAP_MAX;
    repeat (40) send_random();
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 4; phase++) begin
      write_window(WSIZE_BITS'($urandom_range(15, 0)));
      tx_gap_max   = (phase == 2) ? 0 : GAP_MAX;
      rx_stall_max = (phase == 2) ? 0 : GAP_MAX;
      repeat (50) send_random();
    end
    tx_gap_max   = GAP_MAX;
    rx_stall_max = GAP_MAX;
  endtask

  initial begin : run_tests
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_SEND;
    payload_i   = '0;
    ack_num_i   = '0;
    ack_ok_i    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_requests();
    test_window_fill();
    test_ack_handling();
    test_window_extremes();
    test_backpressure();
    test_full_windows();
    test_random_mix();
    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
